/* rtl/core/b2da_pkg.sv */
`timescale 1ns / 1ps

package b2da_pkg;

    // ASCII code of '0', truncated to the six bits of the character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  min_length;
    } num_t;

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last;
    } digit_t;

    // Per-cycle command shared by every cell of the digit chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // correct by three when above four, then shift one bit in
        logic shift;   // take the neighbor's whole digit
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/b2da_cell.sv */
`timescale 1ns / 1ps

// One decimal digit of the shift-and-add-3 chain.
module b2da_cell
    import b2da_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,
    input  logic [3:0] digit_in,
    output logic       bit_out,
    output logic [3:0] digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] adjusted;

    // add three to any digit of five or more before the shift
    assign adjusted  = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out   = adjusted[3];
    assign digit_out = digit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            digit_reg <= 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_reg <= {adjusted[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_reg <= digit_in;
        end
    end

endmodule

/* rtl/core/binary_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// A value taken in is shifted through the bit-serial digit chain (one bit per cycle),
// leading zero digits are stripped (at most 19 for 64-bit values), and the characters
// go out one per cycle while the receiver does not stall. A new value is taken only
// once the last character of the previous one has been registered.
// Reset: asynchronous, active low; clears sequencer, counters and output valid.
// Digit cells and payload registers have no reset; cells clear on each transfer in.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int MAX_LENGTH = 32,
    parameter int VALUE_BITS = 64
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   num_valid,
    output logic   num_stall,
    input  num_t   num,
    output logic   digit_valid,
    input  logic   digit_stall,
    output digit_t digit
);

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [6:0]       MAX_LEN_C  = 7'(MAX_LENGTH);
    localparam logic [LEN_W-1:0] NUM_DIG_C  = LEN_W'(NUM_DIGITS);
    localparam logic [BIT_W-1:0] VAL_BITS_C = BIT_W'(VALUE_BITS);
    localparam logic [DIG_IDX_W-1:0] LZ_MAX_C = DIG_IDX_W'(NUM_DIGITS - 1);

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_IDX_W-1:0]  lz_cnt_reg, lz_cnt_next;
    logic [LEN_W-1:0]      min_len_reg, min_len_next;
    logic [LEN_W-1:0]      pad_cnt_reg, pad_cnt_next;
    logic [LEN_W-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    digit_t                out_data_reg, out_data_next;

    // Sequencer commands
    cell_ctrl_t cell_ctrl;
    logic       load_item;
    logic       conv_step;
    logic       strip_step;
    logic       strip_done;
    logic       emit_pad;
    logic       emit_digit;

    logic       accept;
    logic       slot_free;
    logic       top_zero;
    logic [LEN_W-1:0] ndig;
    logic [LEN_W-1:0] pad_calc;

    // Digit chain wiring: cell 0 is the ones digit, the top cell the most significant
    logic [NUM_DIGITS:0]     bit_link;
    logic [3:0]              digit_link [NUM_DIGITS+1];

    assign accept    = num_valid && !num_stall;
    assign num_stall = (state_reg != ST_IDLE);

    // The output register may take a character when empty or while being drained
    assign slot_free = !out_valid_reg || !digit_stall;
    assign top_zero  = (digit_link[NUM_DIGITS] == 4'd0);

    assign bit_link[0]   = value_reg[VALUE_BITS-1];
    assign digit_link[0] = 4'd0;

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        b2da_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .bit_in    (bit_link[i]),
            .digit_in  (digit_link[i]),
            .bit_out   (bit_link[i+1]),
            .digit_out (digit_link[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (!top_zero || lz_cnt_reg == LZ_MAX_C)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && pad_cnt_reg == '0 && dig_cnt_reg == LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        load_item  = 1'b0;
        conv_step  = 1'b0;
        strip_step = 1'b0;
        strip_done = 1'b0;
        emit_pad   = 1'b0;
        emit_digit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                load_item = accept;
            end
            ST_CONVERT:
            begin
                conv_step = 1'b1;
            end
            ST_STRIP:
            begin
                // drop one leading zero digit per cycle, keep at least one digit
                if (top_zero && lz_cnt_reg != LZ_MAX_C)
                begin
                    strip_step = 1'b1;
                end
                else
                begin
                    strip_done = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit_pad   = (pad_cnt_reg != '0);
                    emit_digit = (pad_cnt_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
        cell_ctrl.clear  = load_item;
        cell_ctrl.dabble = conv_step;
        cell_ctrl.shift  = strip_step || emit_digit;
    end

    // Significant digit count and padding, valid while leaving the strip phase
    assign ndig     = NUM_DIG_C - LEN_W'(lz_cnt_reg);
    assign pad_calc = (min_len_reg > ndig) ? min_len_reg - ndig : '0;

    // Datapath next values
    always_comb
    begin
        value_next     = value_reg;
        bit_cnt_next   = bit_cnt_reg;
        lz_cnt_next    = lz_cnt_reg;
        min_len_next   = min_len_reg;
        pad_cnt_next   = pad_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (load_item)
        begin
            value_next   = num.value[VALUE_BITS-1:0];
            bit_cnt_next = VAL_BITS_C;
            lz_cnt_next  = '0;
            // saturate the requested length at MAX_LENGTH
            if ({1'b0, num.min_length} > MAX_LEN_C)
            begin
                min_len_next = MAX_LEN_C[LEN_W-1:0];
            end
            else
            begin
                min_len_next = LEN_W'(num.min_length);
            end
        end

        if (conv_step)
        begin
            value_next   = {value_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_W'(1);
        end

        if (strip_step)
        begin
            lz_cnt_next = lz_cnt_reg + DIG_IDX_W'(1);
        end

        if (strip_done)
        begin
            pad_cnt_next = pad_calc;
            dig_cnt_next = ndig;
        end

        // drain the output register on transfer out
        if (out_valid_reg && !digit_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (emit_pad)
        begin
            pad_cnt_next             = pad_cnt_reg - LEN_W'(1);
            out_valid_next           = 1'b1;
            out_data_next.digit_char = ASCII_ZERO;
            out_data_next.last       = 1'b0;
        end

        if (emit_digit)
        begin
            dig_cnt_next             = dig_cnt_reg - LEN_W'(1);
            out_valid_next           = 1'b1;
            out_data_next.digit_char = ASCII_ZERO + {2'b00, digit_link[NUM_DIGITS]};
            out_data_next.last       = (dig_cnt_reg == LEN_W'(1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            lz_cnt_reg    <= '0;
            pad_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            lz_cnt_reg    <= lz_cnt_next;
            pad_cnt_reg   <= pad_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        min_len_reg  <= min_len_next;
        out_data_reg <= out_data_next;
    end

    assign digit_valid = out_valid_reg;
    assign digit       = out_data_reg;

endmodule

/* dv/binary_to_decimal_ascii_test.sv */
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
    import b2da_pkg::*;

    localparam int MAX_LEN     = 32;
    localparam int VAL_BITS    = 64;
    localparam int MAX_DIGITS  = 20;
    localparam logic [63:0] VALUE_MASK =
        (VAL_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << VAL_BITS) - 64'd1);

    // Worst value: a full 64-bit conversion, 19 stripped zeros, 32 characters,
    // each character held off by the receiver's random wait. Allow that many times over.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Settle time once nothing is expected: a bit over the first-character latency.
    localparam int SETTLE_CYCLES = 120;
    // Length of the long output hold-off that forces the block to back up.
    localparam int LONG_HOLD     = 400;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   num_valid   = 1'b0;
    logic   num_stall;
    num_t   num         = '0;
    logic   digit_valid;
    logic   digit_stall = 1'b0;
    digit_t digit;

    // Characters still owed by the block, oldest first.
    digit_t expected_chars[$];

    // Idling switches for the sender and the receiver.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    // Non-zero asks the receiver to hold off that many cycles once.
    int hold_off_request = 0;

    int unsigned error_count   = 0;
    int unsigned values_sent   = 0;
    int unsigned chars_checked = 0;
    int unsigned hold_offs     = 0;
    int unsigned cycle_count   = 0;

    binary_to_decimal_ascii #(
        .MAX_LENGTH (MAX_LEN),
        .VALUE_BITS (VAL_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_valid   (num_valid),
        .num_stall   (num_stall),
        .num         (num),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    // Build the decimal text of one value and queue its characters.
    // Digits come out least significant first; zero still gives one digit.
    task automatic predict_text(input num_t item);
        logic [63:0] rest;
        logic [63:0] rem;
        logic [3:0]  dec [0:MAX_DIGITS-1];
        logic [5:0]  ch;
        int          n_digits;
        int          width;
        int          n_pad;
        int          k;
        digit_t      want;
        rest     = item.value & VALUE_MASK;
        n_digits = 0;
        do
        begin
            rem            = rest % 64'd10;
            dec[n_digits]  = rem[3:0];
            rest           = rest / 64'd10;
            n_digits++;
        end while (rest != 64'd0 && n_digits < MAX_DIGITS);

        // Saturate the requested width, then never cut digits off.
        width = (int'(item.min_length) > MAX_LEN) ? MAX_LEN : int'(item.min_length);
        if (n_digits > width)
            width = n_digits;
        if (width > MAX_LEN)
            width = MAX_LEN;
        n_pad = width - n_digits;

        for (k = 0; k < width; k++)
        begin
            if (k < n_pad)
                ch = ASCII_ZERO;
            else
                ch = ASCII_ZERO + {2'b00, dec[n_digits - 1 - (k - n_pad)]};
            want.digit_char = ch;
            want.last       = (k == width - 1);
            expected_chars.insert(expected_chars.size(), want);
        end
    endtask

    // Offer one value and hold it until the block takes it. Valid stays high
    // after the transfer so a zero-gap follow-up goes out back to back.
    task automatic send_number(input logic [63:0] value, input logic [5:0] min_length);
        num_t item;
        int   gap;
        item.value      = value;
        item.min_length = min_length;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            num_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num       <= item;
        num_valid <= 1'b1;
        do @(posedge clk); while (num_stall);
        predict_text(item);
        values_sent++;
    endtask

    // Drop valid and let every owed character come out.
    task automatic wait_for_text();
        num_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [5:0] got,
                                   input logic [5:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d (character %0d)",
                 $realtime, what, got, want, chars_checked);
    endtask

    // Mix of widths: shifted-down random, full 64-bit, tiny, and values that
    // sit right at a power of ten where the digit count changes.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p10;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: v = v >> $urandom_range(0, 63);
            2:    v = 64'($urandom_range(0, 99));
            3:
            begin
                p10 = 64'd1;
                for (k = $urandom_range(0, 19); k > 0; k--)
                    p10 = p10 * 64'd10;
                v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Mostly legal widths, now and then past the saturation point.
    function automatic logic [5:0] random_min_length();
        if ($urandom_range(0, 9) < 8)
            return 6'($urandom_range(0, MAX_LEN));
        return 6'($urandom_range(MAX_LEN + 1, 63));
    endfunction

    // Digit-count extremes: zero, one digit, the first two-digit and
    // three-digit values, the largest 19-digit value, 10^19 and all ones.
    task automatic test_digit_extremes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_number(64'd0, 6'd0);
        send_number(64'd0, 6'd1);
        send_number(64'd1, 6'd0);
        send_number(64'd9, 6'd0);
        send_number(64'd10, 6'd0);
        send_number(64'd99, 6'd2);
        send_number(64'd100, 6'd0);
        send_number(64'd9999999999999999999, 6'd0);
        send_number(64'd10000000000000000000, 6'd0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_number(64'h8000_0000_0000_0000, 6'd0);
        wait_for_text();
    endtask

    // Padding: zero padded out, widths below, at and above the digit count,
    // and widths past the limit that have to saturate.
    task automatic test_zero_padding();
        send_number(64'd0, 6'd32);
        send_number(64'd0, 6'd33);
        send_number(64'd7, 6'd5);
        send_number(64'd12345, 6'd3);
        send_number(64'd12345, 6'd5);
        send_number(64'd12345, 6'd6);
        send_number(64'd10000000000000000000, 6'd31);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 6'd21);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, 6'd32);
        send_number(64'd42, 6'd63);
        send_number(64'd5, 6'd31);
        wait_for_text();
    endtask

    // Random values in four stretches, each with a different idling mix so
    // gaps land on conversion, stripping and emission alike.
    task automatic test_random_values();
        int chunk;
        int n;
        for (chunk = 0; chunk < 4; chunk++)
        begin
            tx_idle = (chunk == 0) || (chunk == 2);
            rx_idle = (chunk == 0) || (chunk == 3);
            for (n = 0; n < 100; n++)
                send_number(random_value(), random_min_length());
        end
        wait_for_text();
    endtask

    // Hold the output off for a long stretch while values keep coming, so
    // the block fills up and stalls its input.
    task automatic test_output_hold_off();
        int n;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_off_request = LONG_HOLD;
        for (n = 0; n < 10; n++)
            send_number(random_value(), random_min_length());
        wait_for_text();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Receiver: draw a wait before every character, or take a long
    // hold-off when one is asked for. Stall is touched once per edge.
    initial
    begin : receiver
        int hold;
        forever
        begin
            if (hold_off_request > 0)
            begin
                hold = hold_off_request;
                hold_off_request = 0;
                hold_offs++;
            end
            else
                hold = rx_idle ? $urandom_range(0, 4) : 0;
            if (hold > 0)
            begin
                digit_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            digit_stall <= 1'b0;
            do @(posedge clk); while (!(digit_valid && !digit_stall));
        end
    end

    // Checker: every character transfer is matched with the oldest owed one.
    initial
    begin : char_checker
        digit_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && digit_valid && !digit_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected character", digit.digit_char, 6'd0);
                else
                begin
                    want = expected_chars.pop_front();
                    if (digit.digit_char !== want.digit_char)
                        report_mismatch("digit_char", digit.digit_char, want.digit_char);
                    if (digit.last !== want.last)
                        report_mismatch("last", {5'd0, digit.last}, {5'd0, want.last});
                end
                chars_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d characters still owed",
                 cycle_count, expected_chars.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : main
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_digit_extremes();
        test_zero_padding();
        test_output_hold_off();
        test_random_values();

        // Let any stray character show up before closing.
        wait_for_text();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d values into %0d checked characters across digit extremes,",
                 values_sent, chars_checked);
        $display("padding and saturation, random widths and %0d long output hold-off(s).",
                 hold_offs);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
